// ===== rtl/cbm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the command tokenizer and bracket matcher
// no dependencies

package cbm_pkg;

  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned POS_W      = 16;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register word index (paddr[2])
  localparam logic [0:0] REG_DEBUG     = 1'b0;
  localparam logic [0:0] REG_EXTENSION = 1'b1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_LEFT      = 4'd2,
    OP_RIGHT     = 4'd3,
    OP_LOOP      = 4'd4,
    OP_ENDLOOP   = 4'd5,
    OP_PRINT     = 4'd6,
    OP_SCAN      = 4'd7,
    OP_BREAK     = 4'd8,
    OP_NEWTHREAD = 4'd9,
    OP_ENDTHREAD = 4'd10,
    OP_LOCK      = 4'd11,
    OP_UNLOCK    = 4'd12,
    OP_SLEEP     = 4'd13,
    OP_END       = 4'd14
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_DEEP     = 3'd4,
    ST_LONG     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]       source_char;
    logic [POS_W-1:0] line_number;
    logic [POS_W-1:0] column_number;
    logic             is_end;
  } in_item_t;

  typedef struct packed {
    opcode_e               opcode;
    logic [INDEX_BITS-1:0] token_index;
    logic [POS_W-1:0]      token_line;
    logic [POS_W-1:0]      token_column;
    logic [INDEX_BITS-1:0] partner_index;
    logic                  has_partner;
    status_e               status;
    logic [INDEX_BITS-1:0] error_index;
  } out_item_t;

  typedef struct packed {
    logic                  thread;
    logic [INDEX_BITS-1:0] idx;
  } stk_entry_t;

endpackage

// ===== rtl/cbm_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module cbm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/command_tokenizer_bracket_matcher_top.sv =====
`timescale 1ns / 1ps
// top level of the command tokenizer and bracket matcher
// depends on cbm_pkg and cbm_ram

// Takes one source character per cycle while the output buffer has room and
// returns at most one token per request; with the output buffer empty the token
// is offered the cycle after acceptance. The top of the opener stack sits in a
// register; the entries below it live in a STACK_DEPTH-entry ram whose read
// address always points just below the top, so a push or pop completes without
// a wait, with a write forward register covering the ram's registered read. A
// two-entry output buffer lets a request be taken while a token waits. The stack
// needs no clearing pass after reset or after the end request. Configuration
// registers: debug enable (semicolon as break) at 0x0, extension enable at 0x4.
module command_tokenizer_bracket_matcher_top #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cbm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cbm_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbm_pkg::APB_AW-1:0]   paddr,
  input  logic [cbm_pkg::APB_DW-1:0]   pwdata,
  output logic [cbm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  import cbm_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // configuration
  logic       debug_q, ext_q;
  logic       cfg_we;
  logic [0:0] cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[APB_AW-1:2];

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      REG_DEBUG:     prdata = APB_DW'(debug_q);
      REG_EXTENSION: prdata = APB_DW'(ext_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debug_q <= 1'b0;
      ext_q   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_DEBUG:     debug_q <= pwdata[0];
        REG_EXTENSION: ext_q   <= pwdata[0];
        default:       debug_q <= debug_q;
      endcase
    end
  end

  // decode
  logic    op_vld;
  opcode_e op;

  always_comb begin
    op_vld = 1'b1;
    op     = OP_ADD;
    case (in_data_i.source_char)
      CH_PLUS:   op = OP_ADD;
      CH_MINUS:  op = OP_SUB;
      CH_LT:     op = OP_LEFT;
      CH_GT:     op = OP_RIGHT;
      CH_LBRACK: op = OP_LOOP;
      CH_RBRACK: op = OP_ENDLOOP;
      CH_DOT:    op = OP_PRINT;
      CH_COMMA:  op = OP_SCAN;
      CH_SEMI: begin
        op     = OP_BREAK;
        op_vld = debug_q;
      end
      CH_LBRACE: begin
        op     = OP_NEWTHREAD;
        op_vld = ext_q;
      end
      CH_RBRACE: begin
        op     = OP_ENDTHREAD;
        op_vld = ext_q;
      end
      CH_HASH: begin
        op     = OP_LOCK;
        op_vld = ext_q;
      end
      CH_PCT: begin
        op     = OP_UNLOCK;
        op_vld = ext_q;
      end
      CH_PIPE: begin
        op     = OP_SLEEP;
        op_vld = ext_q;
      end
      default: op_vld = 1'b0;
    endcase
  end

  // stack and counters
  logic [SPW-1:0]        sp_q, sp_d;
  logic [INDEX_BITS:0]   cnt_q, cnt_d;
  status_e               err_q, err_d;
  logic [INDEX_BITS-1:0] epos_q, epos_d;
  stk_entry_t            tos_q, tos_d;
  stk_entry_t            wfwd_q;
  logic                  bypass_q;
  stk_entry_t            ram_rdata, below;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic                  in_acc, emit;
  logic                  is_opener, is_closer;
  out_item_t             res;

  assign in_acc    = in_valid_i && in_ready_o;
  assign is_opener = (op == OP_LOOP) || (op == OP_NEWTHREAD);
  assign is_closer = (op == OP_ENDLOOP) || (op == OP_ENDTHREAD);
  assign below     = bypass_q ? wfwd_q : ram_rdata;
  assign ram_waddr = AW'(sp_q - SPW'(1));
  assign ram_raddr = AW'(sp_d - SPW'(2));

  always_comb begin
    sp_d   = sp_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    epos_d = epos_q;
    tos_d  = tos_q;
    ram_we = 1'b0;
    emit   = 1'b0;

    res.opcode        = op;
    res.token_index   = cnt_q[INDEX_BITS-1:0];
    res.token_line    = in_data_i.line_number;
    res.token_column  = in_data_i.column_number;
    res.partner_index = '0;
    res.has_partner   = 1'b0;
    res.status        = ST_OK;
    res.error_index   = '0;

    if (in_acc) begin
      if (in_data_i.is_end) begin
        emit       = 1'b1;
        res.opcode = OP_END;
        if (err_q != ST_OK) begin
          res.status      = err_q;
          res.error_index = epos_q;
        end else if (sp_q != '0) begin
          res.status      = ST_UNCLOSED;
          res.error_index = tos_q.idx;
        end
        sp_d   = '0;
        cnt_d  = '0;
        err_d  = ST_OK;
        epos_d = '0;
      end else if (err_q == ST_OK && op_vld) begin
        emit = 1'b1;
        if (cnt_q[INDEX_BITS]) begin
          res.token_index = '1;
          res.status      = ST_LONG;
        end else begin
          if (is_opener) begin
            if (sp_q == SPW'(STACK_DEPTH)) begin
              res.status = ST_DEEP;
            end else begin
              ram_we       = (sp_q != '0);
              tos_d.thread = (op == OP_NEWTHREAD);
              tos_d.idx    = cnt_q[INDEX_BITS-1:0];
              sp_d         = sp_q + SPW'(1);
            end
          end else if (is_closer) begin
            if (sp_q == '0) begin
              res.status = ST_EMPTY;
            end else if (tos_q.thread != (op == OP_ENDTHREAD)) begin
              res.status = ST_MISMATCH;
            end else begin
              res.partner_index = tos_q.idx;
              res.has_partner   = 1'b1;
              tos_d             = below;
              sp_d              = sp_q - SPW'(1);
            end
          end
          cnt_d = cnt_q + (INDEX_BITS + 1)'(1);
        end
        if (res.status != ST_OK) begin
          err_d           = res.status;
          epos_d          = res.token_index;
          res.error_index = res.token_index;
        end
      end
    end
  end

  cbm_ram #(
    .WIDTH ($bits(stk_entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      cnt_q    <= '0;
      err_q    <= ST_OK;
      epos_q   <= '0;
      bypass_q <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      epos_q   <= epos_d;
      bypass_q <= ram_we;
    end
  end

  // write forward: the pushed entry is the one read back next cycle
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (ram_we) begin
      wfwd_q <= tos_q;
    end
  end

  // two-entry output buffer
  out_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fcnt_q;
  logic       pop;

  assign in_ready_o  = (fcnt_q != 2'd2);
  assign out_valid_o = (fcnt_q != 2'd0);
  assign out_data_o  = slot_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fcnt_q <= 2'd0;
    end else begin
      wr_q   <= wr_q ^ emit;
      rd_q   <= rd_q ^ pop;
      fcnt_q <= fcnt_q + 2'(emit) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      slot_q[wr_q] <= res;
    end
  end

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.is_end |=> sp_q == '0 && cnt_q == '0 && err_q == ST_OK)
    else $error("state not cleared after end request");

  a_error_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !(in_acc && in_data_i.is_end) |=> $stable(sp_q) && $stable(cnt_q))
    else $error("stack or count moved after an error");

  a_partner_on_closer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_partner |->
      (out_data_o.opcode == OP_ENDLOOP || out_data_o.opcode == OP_ENDTHREAD) &&
      out_data_o.status == ST_OK)
    else $error("partner reported on a token that is not a matched closer");

endmodule
